@@ design/mvm_pkg.sv @@
// shared types and constants for the matrix vector multiply core
`timescale 1ns / 1ps

package mvm_pkg;

    // accumulator and dot product width
    localparam int ACC_BITS = 48;

    // fixed payload field widths
    localparam int NEURON_BITS  = 6;
    localparam int ELEMENT_BITS = 8;
    localparam int SAMPLE_BITS  = 16;

    // largest row length that element_index can address
    localparam int ELEMENT_SPAN = 256;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 9;
    localparam int CFG_N_BITS     = 7;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_COUNT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INPUT_LENGTH = 1'b1;

    // command codes
    localparam logic CMD_LOAD_WEIGHT  = 1'b0;
    localparam logic CMD_FEED_ELEMENT = 1'b1;

    // one input transaction
    typedef struct packed {
        logic                          cmd;
        logic [NEURON_BITS-1:0]        neuron_index;
        logic [ELEMENT_BITS-1:0]       element_index;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic [NEURON_BITS-1:0]     output_index;
        logic signed [ACC_BITS-1:0] dot_value;
        logic                       last_of_run;
    } t_result;

endpackage

@@ design/matrix_vector_multiply_core.sv @@
// top level of the fully connected layer core: control, mac pipeline, stores
//
// usage
//   configuration: write output_count (index 0) and input_length (index 1)
//   through i_cfg_valid / o_cfg_ready while the core is idle; values are
//   saturated into the supported range. reset sets them to their maxima.
//   commands: a transaction is taken at a clock edge where start is high and
//   busy is low. a weight load writes the weight store and busy stays low.
//   an input element with index below the row length runs a pass over all
//   active neurons: one weight read and one accumulator read-modify-write
//   per neuron through a shared multiply-accumulate, so busy stays high
//   until the sum of the last active neuron has left the pipeline. elements
//   past the row length are taken and dropped; busy stays low.
//   results: on the last element of a row the pass sends the finished dot
//   products instead of writing them back, one per cycle on o_result with
//   o_strobe high, in neuron order,
//   last_of_run on the final one. the receiver cannot stall this stream.
//   the accumulators then read as zero again.
//   reset clears control state and all accumulator valid bits at once;
//   weights are undefined until loaded.
`timescale 1ns / 1ps

module matrix_vector_multiply_core #(
    parameter int MAX_OUTPUTS = 64,
    parameter int MAX_LENGTH  = 256,
    parameter int DATA_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  mvm_pkg::t_item                      i_item,
    output logic                                o_strobe,
    output mvm_pkg::t_result                    o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mvm_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [mvm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int NB     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int WDEPTH = MAX_OUTPUTS * MAX_LENGTH;
    localparam int AW     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int KMAX   = (MAX_LENGTH < mvm_pkg::ELEMENT_SPAN) ?
                            MAX_LENGTH : mvm_pkg::ELEMENT_SPAN;
    localparam int KB     = mvm_pkg::ELEMENT_BITS;
    localparam int PW     = 2 * DATA_BITS;
    localparam int AB     = mvm_pkg::ACC_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state                  r_state;
    logic [NB-1:0]           r_n;
    logic [AW-1:0]           r_waddr;
    logic                    r_last;
    logic                    r_s1_vld;
    logic                    r_s2_vld;
    logic                    r_strobe;
    logic [MAX_OUTPUTS-1:0]  r_acc_vld;
    logic [NB-1:0]           r_n_last;
    logic [KB-1:0]           r_k_last;

    logic [DATA_BITS-1:0]    r_x;
    logic [NB-1:0]           r_s1_n;
    logic [NB-1:0]           r_s2_n;
    logic signed [PW-1:0]    r_prod;
    logic [AB-1:0]           r_acc;
    mvm_pkg::t_result        r_result;

    logic                    accept;
    logic                    feed_go;
    logic                    wt_we;
    logic [AW-1:0]           wt_waddr;
    logic [DATA_BITS-1:0]    sample_bits;
    logic [DATA_BITS-1:0]    wt_rdata;
    logic [AB-1:0]           acc_rdata;
    logic signed [PW-1:0]    prod;
    logic [AB-1:0]           sum;
    logic                    s2_end;
    logic                    acc_we;
    logic [mvm_pkg::CFG_N_BITS-1:0] cfg_n;
    logic [mvm_pkg::CFG_DATA_BITS-1:0] cfg_k;

    // command decode
    assign accept      = start && !busy;
    assign sample_bits = DATA_BITS'($unsigned(i_item.sample));
    assign feed_go     = accept && (i_item.cmd == mvm_pkg::CMD_FEED_ELEMENT) &&
                         (i_item.element_index <= r_k_last);
    assign wt_we       = accept && (i_item.cmd == mvm_pkg::CMD_LOAD_WEIGHT) &&
                         (int'(i_item.neuron_index) < MAX_OUTPUTS) &&
                         (int'(i_item.element_index) < MAX_LENGTH);
    assign wt_waddr    = AW'(i_item.neuron_index) * AW'(MAX_LENGTH) +
                         AW'(i_item.element_index);

    // weight store
    mvm_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (WDEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (sample_bits),
        .i_raddr (r_waddr),
        .o_rdata (wt_rdata)
    );

    // accumulator store, written back only on rows that continue
    assign s2_end = (r_s2_n == r_n_last);
    assign acc_we = r_s2_vld && !r_last;

    mvm_ram #(
        .WIDTH (AB),
        .DEPTH (MAX_OUTPUTS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (r_s2_n),
        .i_wdata (sum),
        .i_raddr (r_n),
        .o_rdata (acc_rdata)
    );

    // configuration registers, saturated on write
    assign o_cfg_ready = !busy;
    assign cfg_n       = i_cfg_data[mvm_pkg::CFG_N_BITS-1:0];
    assign cfg_k       = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_last <= NB'(MAX_OUTPUTS - 1);
            r_k_last <= KB'(KMAX - 1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mvm_pkg::CFG_OUTPUT_COUNT: begin
                    if (cfg_n == '0) begin
                        r_n_last <= '0;
                    end else if (int'(cfg_n) > MAX_OUTPUTS) begin
                        r_n_last <= NB'(MAX_OUTPUTS - 1);
                    end else begin
                        r_n_last <= NB'(cfg_n - 7'd1);
                    end
                end
                mvm_pkg::CFG_INPUT_LENGTH: begin
                    if (cfg_k == '0) begin
                        r_k_last <= '0;
                    end else if (int'(cfg_k) > KMAX) begin
                        r_k_last <= KB'(KMAX - 1);
                    end else begin
                        r_k_last <= KB'(cfg_k - 9'd1);
                    end
                end
            endcase
        end
    end

    // stage 2 multiply, stage 3 accumulate
    assign prod = $signed(wt_rdata) * $signed(r_x);
    assign sum  = r_acc + AB'(r_prod);

    // sequencer, pipeline valids, valid bits and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_n       <= '0;
            r_waddr   <= '0;
            r_last    <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_strobe  <= 1'b0;
            r_acc_vld <= '0;
        end else begin
            r_s1_vld <= (r_state == ST_RUN);
            r_s2_vld <= r_s1_vld;
            r_strobe <= r_s2_vld && r_last;
            unique case (r_state)
                ST_IDLE: begin
                    if (feed_go) begin
                        r_state <= ST_RUN;
                        r_n     <= '0;
                        r_waddr <= AW'(i_item.element_index);
                        r_last  <= (i_item.element_index == r_k_last);
                    end
                end
                ST_RUN: begin
                    r_n     <= r_n + 1'b1;
                    r_waddr <= r_waddr + AW'(MAX_LENGTH);
                    if (r_n == r_n_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_s2_vld && s2_end) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // mark written entries, clear all when a row ends
            if (r_s2_vld && r_last && s2_end) begin
                r_acc_vld <= '0;
            end else if (acc_we) begin
                r_acc_vld[r_s2_n] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (feed_go) begin
            r_x <= sample_bits;
        end
        r_s1_n <= r_n;
        r_s2_n <= r_s1_n;
        r_prod <= prod;
        r_acc  <= r_acc_vld[r_s1_n] ? acc_rdata : '0;
        if (r_s2_vld && r_last) begin
            r_result.output_index <= mvm_pkg::NEURON_BITS'(r_s2_n);
            r_result.dot_value    <= $signed(sum);
            r_result.last_of_run  <= s2_end;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // results only come from the final stage of a closing pass
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_s2_vld && r_last))
        else $error("result strobe without a closing pass");

    // the last result of a row leaves all accumulators cleared
    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_of_run) |-> (r_acc_vld == '0))
        else $error("accumulators not cleared at row end");

    // an idle core has an empty pipeline
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_s1_vld && !r_s2_vld))
        else $error("pipeline busy while idle");

    // results of a row come back to back in neuron order
    a_result_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_of_run) |=>
            (o_strobe && (o_result.output_index ==
             mvm_pkg::NEURON_BITS'($past(o_result.output_index) + 1'b1))))
        else $error("result sequence broken");

    // no weight write can disturb a running pass
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wt_we |-> (r_state == ST_IDLE && !r_s1_vld))
        else $error("weight write during a pass");

endmodule

@@ design/mvm_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/tb_matrix_vector_multiply_core.sv @@
// testbench for the matrix vector multiply core: dot product scoreboard and command stimulus
`timescale 1ns / 1ps

module tb_matrix_vector_multiply_core;

    localparam int MAX_NEURONS   = 64;
    localparam int SETTLE_CYCLES = MAX_NEURONS + 8;
    localparam int TOTAL_ITEMS   = 170;
    localparam int TIMEOUT_NS    = 2_000_000;

    // tracks weights, running sums and the dot products still owed by the core
    class dot_product_tracker;
        logic signed [mvm_pkg::SAMPLE_BITS-1:0] weights [0:MAX_NEURONS*mvm_pkg::ELEMENT_SPAN-1];
        bit                            loaded [0:MAX_NEURONS*mvm_pkg::ELEMENT_SPAN-1];
        logic signed [mvm_pkg::ACC_BITS-1:0] sums [0:MAX_NEURONS-1];
        int unsigned                   n_active;
        int unsigned                   k_active;
        mvm_pkg::t_result              pending_dots[$];
        int unsigned                   errors;

        function new();
            n_active = MAX_NEURONS;
            k_active = mvm_pkg::ELEMENT_SPAN;
            errors   = 0;
            foreach (sums[i]) sums[i] = '0;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        // register writes saturate into the supported range
        function void set_register(logic [mvm_pkg::CFG_INDEX_BITS-1:0] idx,
                                   logic [mvm_pkg::CFG_DATA_BITS-1:0] data);
            int unsigned v;
            if (idx == mvm_pkg::CFG_OUTPUT_COUNT) begin
                v = data[mvm_pkg::CFG_N_BITS-1:0];
                n_active = (v < 1) ? 1 : ((v > MAX_NEURONS) ? MAX_NEURONS : v);
            end else if (idx == mvm_pkg::CFG_INPUT_LENGTH) begin
                v = data;
                k_active = (v < 1) ? 1 :
                           ((v > mvm_pkg::ELEMENT_SPAN) ? mvm_pkg::ELEMENT_SPAN : v);
            end
        endfunction

        function bit is_loaded(int n, int k);
            return loaded[n*mvm_pkg::ELEMENT_SPAN + k];
        endfunction

        // one accepted command transaction
        function void accept_command(mvm_pkg::t_item it);
            int unsigned       kk;
            int unsigned       n;
            logic signed [31:0] prod;
            mvm_pkg::t_result  r;
            kk = it.element_index;
            if (it.cmd == mvm_pkg::CMD_LOAD_WEIGHT) begin
                weights[it.neuron_index*mvm_pkg::ELEMENT_SPAN + kk] = it.sample;
                loaded[it.neuron_index*mvm_pkg::ELEMENT_SPAN + kk]  = 1'b1;
                return;
            end
            // elements past the row are dropped
            if (kk >= k_active)
                return;
            for (n = 0; n < n_active; n++) begin
                prod = $signed(it.sample) *
                       $signed(weights[n*mvm_pkg::ELEMENT_SPAN + kk]);
                sums[n] = sums[n] + {{(mvm_pkg::ACC_BITS-32){prod[31]}}, prod};
            end
            // last element of the row flushes every active sum
            if (kk == k_active - 1) begin
                for (n = 0; n < n_active; n++) begin
                    r.output_index = mvm_pkg::NEURON_BITS'(n);
                    r.dot_value    = sums[n];
                    r.last_of_run  = (n == n_active - 1);
                    pending_dots.push_back(r);
                end
                foreach (sums[i]) sums[i] = '0;
            end
        endfunction

        function void match_result(mvm_pkg::t_result got);
            mvm_pkg::t_result want;
            if (pending_dots.size() == 0) begin
                $error("result with nothing expected: output_index %0d dot_value %0d",
                       got.output_index, got.dot_value);
                errors++;
                return;
            end
            want = pending_dots.pop_front();
            if (got.output_index !== want.output_index) begin
                $error("output_index: expected %0d, got %0d",
                       want.output_index, got.output_index);
                errors++;
            end
            if (got.dot_value !== want.dot_value) begin
                $error("dot_value: expected %0d, got %0d", want.dot_value, got.dot_value);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0b, got %0b",
                       want.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    mvm_pkg::t_item                     i_item;
    logic                               o_strobe;
    mvm_pkg::t_result                   o_result;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [mvm_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [mvm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    dot_product_tracker tracker;
    int unsigned        idle_pct;
    int unsigned        items_sent;

    matrix_vector_multiply_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result monitor, the core cannot be stalled
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            tracker.match_result(o_result);
    end

    function automatic logic [mvm_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return mvm_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // one command transaction, start held until the core takes it
    task automatic send_item(input mvm_pkg::t_item it);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        tracker.accept_command(it);
    endtask

    task automatic load_weight(input int n, input int k,
                               input logic [mvm_pkg::SAMPLE_BITS-1:0] s);
        mvm_pkg::t_item it;
        it.cmd           = mvm_pkg::CMD_LOAD_WEIGHT;
        it.neuron_index  = mvm_pkg::NEURON_BITS'(n);
        it.element_index = mvm_pkg::ELEMENT_BITS'(k);
        it.sample        = s;
        send_item(it);
    endtask

    // feeds one row element, loading any missing weight of its column first
    task automatic feed_element(input int k, input logic [mvm_pkg::SAMPLE_BITS-1:0] x);
        mvm_pkg::t_item it;
        int             n;
        if (k < tracker.k_active) begin
            for (n = 0; n < tracker.n_active; n++)
                if (!tracker.is_loaded(n, k))
                    load_weight(n, k, pick_sample());
        end
        it.cmd           = mvm_pkg::CMD_FEED_ELEMENT;
        it.neuron_index  = mvm_pkg::NEURON_BITS'($urandom_range(0, MAX_NEURONS - 1));
        it.element_index = mvm_pkg::ELEMENT_BITS'(k);
        it.sample        = x;
        send_item(it);
    endtask

    // wait for every owed dot product, then let a running pass finish
    task automatic drain();
        start <= 1'b0;
        while (tracker.pending_dots.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register writes on the configuration channel, core idle
    task automatic set_config(input bit do_n, input logic [mvm_pkg::CFG_DATA_BITS-1:0] n_data,
                              input bit do_k, input logic [mvm_pkg::CFG_DATA_BITS-1:0] k_data);
        if (do_n) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= mvm_pkg::CFG_OUTPUT_COUNT;
            i_cfg_data  <= n_data;
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            tracker.set_register(mvm_pkg::CFG_OUTPUT_COUNT, n_data);
        end
        if (do_k) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= mvm_pkg::CFG_INPUT_LENGTH;
            i_cfg_data  <= k_data;
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            tracker.set_register(mvm_pkg::CFG_INPUT_LENGTH, k_data);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // one row: scattered elements and noise, usually closed by its last element
    task automatic run_row();
        int unsigned k_end;
        int unsigned steps;
        int unsigned j;
        k_end = tracker.k_active - 1;
        steps = $urandom_range(0, 6);
        for (j = 0; j < steps && items_sent < TOTAL_ITEMS; j++) begin
            case ($urandom_range(0, 7))
                0: load_weight($urandom_range(0, MAX_NEURONS - 1),
                               $urandom_range(0, mvm_pkg::ELEMENT_SPAN - 1), pick_sample());
                1: if (tracker.k_active < mvm_pkg::ELEMENT_SPAN)
                       feed_element($urandom_range(tracker.k_active,
                                                   mvm_pkg::ELEMENT_SPAN - 1),
                                    pick_sample());
                default: if (k_end > 0)
                       feed_element($urandom_range(0, k_end - 1), pick_sample());
            endcase
        end
        if (items_sent < TOTAL_ITEMS && $urandom_range(0, 7) != 0)
            feed_element(k_end, pick_sample());
    endtask

    // stimulus
    initial begin
        logic [mvm_pkg::SAMPLE_BITS-1:0]   corner [0:5];
        logic [mvm_pkg::CFG_DATA_BITS-1:0] n_data;
        logic [mvm_pkg::CFG_DATA_BITS-1:0] k_data;
        int unsigned                       sel;
        int unsigned                       guard;
        int                                n;
        int                                k;

        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000};
        tracker     = new();
        idle_pct    = 30;
        items_sent  = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small layer with corner weights and inputs
        set_config(1'b1, 9'd3, 1'b1, 9'd4);
        for (n = 0; n < 3; n++)
            for (k = 0; k < 4; k++)
                load_weight(n, k, corner[(n*4 + k) % 6]);
        // load outside the active area
        load_weight(63, 255, 16'h5555);
        feed_element(0, 16'h8000);
        feed_element(2, 16'h7FFF);
        feed_element(1, 16'hFFFF);
        // repeated element accumulates twice
        feed_element(1, 16'h0001);
        // element past the row is dropped
        feed_element(200, 16'h1234);
        feed_element(3, 16'h8000);
        // row of a single element
        feed_element(3, 16'h7FFF);

        // high bits dropped and zero saturate both sizes to one
        drain();
        set_config(1'b1, 9'h180, 1'b1, 9'd0);
        feed_element(0, 16'h8000);
        feed_element(255, 16'h2222);
        feed_element(0, 16'h7FFF);

        // oversized values saturate to the largest layer
        drain();
        set_config(1'b1, 9'd127, 1'b1, 9'd511);
        feed_element(255, 16'h7FFF);

        // exact maxima
        drain();
        set_config(1'b1, 9'd64, 1'b1, 9'd256);
        feed_element(255, 16'hC000);

        // random layers and rows
        while (items_sent < TOTAL_ITEMS) begin
            drain();
            case ($urandom_range(0, 9))
                0: n_data = mvm_pkg::CFG_DATA_BITS'($urandom_range(0, 511));
                1: n_data = 9'd64;
                default: n_data = mvm_pkg::CFG_DATA_BITS'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0: k_data = mvm_pkg::CFG_DATA_BITS'($urandom_range(0, 511));
                default: k_data = mvm_pkg::CFG_DATA_BITS'($urandom_range(1, 10));
            endcase
            sel = $urandom_range(0, 3);
            set_config(sel != 1, n_data, sel != 0, k_data);
            repeat ($urandom_range(1, 3)) begin
                // no idling in the tail of the run
                if (items_sent + 30 >= TOTAL_ITEMS)
                    idle_pct = 0;
                else
                    case ($urandom_range(0, 2))
                        0: idle_pct = 0;
                        1: idle_pct = 25;
                        default: idle_pct = 60;
                    endcase
                run_row();
            end
        end

        // wait out the remaining dot products
        start <= 1'b0;
        guard = 0;
        while (tracker.pending_dots.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.pending_dots.size() != 0) begin
            $error("%0d expected results never arrived", tracker.pending_dots.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
design/mvm_pkg.sv
design/mvm_ram.sv
design/matrix_vector_multiply_core.sv
tb/tb_matrix_vector_multiply_core.sv
